[rtl/core/vn3_pkg.sv]
// Shared types, widths and constants for the 3D vector normalizer.
`default_nettype none

package vn3_pkg;

  localparam int COMPONENT_BITS = 16;
  localparam int FRAC           = COMPONENT_BITS - 2;
  localparam int NLANES         = 3;

  localparam int QW    = 2 * COMPONENT_BITS - 1;  // component square
  localparam int SW    = 2 * COMPONENT_BITS;      // squared length
  localparam int AW    = 4 * FRAC + 5;            // u^2 * S, accepted
  localparam int BW    = 3 * FRAC + 6;            // u * S, signed
  localparam int CW    = 4 * FRAC + 9;            // candidate sum, signed
  localparam int RW    = FRAC + 1;                // scaled magnitude
  localparam int NSRCH = FRAC + 1;                // one step per result bit
  localparam int NPOS  = FRAC + 3;                // square, sum, search steps
  localparam int POS_LAST = NPOS - 1;

  localparam logic [SW-1:0] S_UNIT = SW'(1) << (2 * FRAC);
  localparam logic [COMPONENT_BITS-1:0] POS_MAX = {1'b0, {(COMPONENT_BITS - 1){1'b1}}};
  localparam logic [COMPONENT_BITS-1:0] NEG_MAG = {1'b1, {(COMPONENT_BITS - 1){1'b0}}};

  typedef logic signed [COMPONENT_BITS-1:0] comp_t;

  localparam comp_t Q_ONE = comp_t'(COMPONENT_BITS'(1) << FRAC);

  typedef struct packed {
    comp_t x_in;
    comp_t y_in;
    comp_t z_in;
  } vec_in_t;

  typedef struct packed {
    comp_t x_out;
    comp_t y_out;
    comp_t z_out;
    logic  ok;
  } vec_out_t;

  typedef struct packed {
    comp_t code;   // scaled and encoded component
    comp_t raw;    // original component, for the unit-length case
  } lane_res_t;

  typedef struct packed {
    logic en;             // pipeline advances
    logic out_from_skid;  // output register takes the skid entry
    logic out_from_pipe;  // output register takes the new result
    logic skid_load;      // skid takes the new result
  } ctl_t;

endpackage

`default_nettype wire

[rtl/core/vn3_ctl.sv]
// Valid tracking, output register and skid control for the normalizer pipeline.
`default_nettype none

module vn3_ctl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output vn3_pkg::ctl_t ctl
);
  import vn3_pkg::*;

  logic [NPOS-1:0] v_r;
  logic            out_v_r;
  logic            skid_v_r;
  logic            en;
  logic            room;
  logic            incoming;

  always_comb begin
    en       = !skid_v_r;
    room     = !out_v_r || out_ready;
    incoming = en && v_r[NPOS-1];
    ctl.en            = en;
    ctl.out_from_skid = room && skid_v_r;
    ctl.out_from_pipe = room && !skid_v_r && incoming;
    ctl.skid_load     = !room && incoming;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r      <= '0;
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      if (en) begin
        v_r <= {v_r[NPOS-2:0], in_valid};
      end
      if (room) begin
        out_v_r <= skid_v_r || incoming;
      end
      if (ctl.out_from_skid) begin
        skid_v_r <= 1'b0;
      end else if (ctl.skid_load) begin
        skid_v_r <= 1'b1;
      end
    end
  end

  assign in_ready  = en;
  assign out_valid = out_v_r;

endmodule

`default_nettype wire

[rtl/core/vn3_lane.sv]
// One component lane: square, then bit-per-stage reciprocal-sqrt scaling search.
`default_nettype none

module vn3_lane (
  input  logic                                          clk,
  input  logic                                          en,
  input  vn3_pkg::comp_t                                comp_in,
  input  logic [vn3_pkg::NSRCH-1:0][vn3_pkg::SW-1:0]    s_stage,
  output logic [vn3_pkg::QW-1:0]                        sq_out,
  output vn3_pkg::lane_res_t                            res
);
  import vn3_pkg::*;

  logic                        neg_r [NPOS];
  comp_t                       raw_r [NPOS];
  logic [QW-1:0]               sq_r  [NPOS-1];
  logic [AW-1:0]               a_r   [NSRCH-1];
  logic signed [BW-1:0]        b_r   [NSRCH-1];
  logic [RW-1:0]               r_r   [NSRCH];

  logic [COMPONENT_BITS-1:0]   mag;
  logic [2*COMPONENT_BITS-1:0] prod;

  always_comb begin
    mag  = comp_in[COMPONENT_BITS-1] ? unsigned'(-comp_in) : unsigned'(comp_in);
    prod = mag * mag;
  end

  // square stage and side-band carry
  always_ff @(posedge clk) begin
    if (en) begin
      neg_r[0] <= comp_in[COMPONENT_BITS-1];
      raw_r[0] <= comp_in;
      sq_r[0]  <= QW'(prod);
      for (int p = 1; p < NPOS; p++) begin
        neg_r[p] <= neg_r[p-1];
        raw_r[p] <= raw_r[p-1];
      end
      for (int p = 1; p < NPOS - 1; p++) begin
        sq_r[p] <= sq_r[p-1];
      end
    end
  end

  assign sq_out = sq_r[0];

  // Search for the largest r with (2r-1)^2 * S <= mag^2 * 2^(2F+2).
  // A = u^2 * S and B = u * S are kept for u = 2r-1, so each step is adds only.
  for (genvar j = 0; j < NSRCH; j++) begin : g_step
    localparam int BIT = FRAC - j;

    logic [AW-1:0]        a_in;
    logic signed [BW-1:0] b_in;
    logic [RW-1:0]        r_in;
    logic signed [CW-1:0] cand;
    logic signed [CW-1:0] m_x;
    logic                 take;

    if (j == 0) begin : g_first
      // r = 0, u = -1
      assign a_in = AW'(s_stage[0]);
      assign b_in = -signed'(BW'(s_stage[0]));
      assign r_in = '0;
    end else begin : g_next
      assign a_in = a_r[j-1];
      assign b_in = b_r[j-1];
      assign r_in = r_r[j-1];
    end

    always_comb begin
      cand = signed'(CW'(a_in)) + (CW'(b_in) <<< (BIT + 2))
           + (signed'(CW'(s_stage[j])) <<< (2 * BIT + 2));
      m_x  = signed'(CW'(sq_r[j+1])) <<< (2 * FRAC + 2);
      // once r reaches 1.0 no further bit may be added
      take = (cand <= m_x) && !r_in[RW-1];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        r_r[j] <= take ? (r_in | (RW'(1) << BIT)) : r_in;
      end
    end

    if (j < NSRCH - 1) begin : g_ab
      always_ff @(posedge clk) begin
        if (en) begin
          if (take) begin
            a_r[j] <= AW'(cand);
            b_r[j] <= b_in + signed'(BW'(s_stage[j]) << (BIT + 1));
          end else begin
            a_r[j] <= a_in;
            b_r[j] <= b_in;
          end
        end
      end
    end
  end

  // sign and clamp
  logic [COMPONENT_BITS-1:0] rx;
  logic [COMPONENT_BITS-1:0] mag_c;

  always_comb begin
    rx = COMPONENT_BITS'(r_r[NSRCH-1]);
    if (neg_r[POS_LAST]) begin
      mag_c    = (rx > NEG_MAG) ? NEG_MAG : rx;
      res.code = signed'(-mag_c);
    end else begin
      mag_c    = (rx > POS_MAX) ? POS_MAX : rx;
      res.code = signed'(mag_c);
    end
    res.raw = raw_r[POS_LAST];
  end

endmodule

`default_nettype wire

[rtl/core/vn3_merge.sv]
// Sums lane squares, tracks zero/unit length and assembles the output item.
`default_nettype none

module vn3_merge (
  input  logic                                           clk,
  input  vn3_pkg::ctl_t                                  ctl,
  input  logic [vn3_pkg::NLANES-1:0][vn3_pkg::QW-1:0]    sq_in,
  input  vn3_pkg::lane_res_t [vn3_pkg::NLANES-1:0]       res_in,
  output logic [vn3_pkg::NSRCH-1:0][vn3_pkg::SW-1:0]     s_stage,
  output vn3_pkg::vec_out_t                              out_data
);
  import vn3_pkg::*;

  logic [NSRCH-1:0][SW-1:0] s_r;
  logic [NSRCH:0]           zero_r;
  logic [NSRCH:0]           unit_r;
  logic [SW-1:0]            s_sum;
  vec_out_t                 res_vec;
  vec_out_t                 out_r;
  vec_out_t                 skid_r;

  function automatic comp_t pick(lane_res_t lr, logic zero, logic unit);
    if (zero) begin
      return '0;
    end else if (unit) begin
      return lr.raw;
    end
    return lr.code;
  endfunction

  assign s_sum = SW'(sq_in[0]) + SW'(sq_in[1]) + SW'(sq_in[2]);

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      s_r[0]    <= s_sum;
      zero_r[0] <= (s_sum == '0);
      unit_r[0] <= (s_sum == S_UNIT);
      for (int k = 1; k < NSRCH; k++) begin
        s_r[k] <= s_r[k-1];
      end
      for (int k = 1; k <= NSRCH; k++) begin
        zero_r[k] <= zero_r[k-1];
        unit_r[k] <= unit_r[k-1];
      end
    end
  end

  assign s_stage = s_r;

  always_comb begin
    res_vec.x_out = pick(res_in[0], zero_r[NSRCH], unit_r[NSRCH]);
    res_vec.y_out = pick(res_in[1], zero_r[NSRCH], unit_r[NSRCH]);
    res_vec.z_out = pick(res_in[2], zero_r[NSRCH], unit_r[NSRCH]);
    res_vec.ok    = !zero_r[NSRCH];
  end

  always_ff @(posedge clk) begin
    if (ctl.skid_load) begin
      skid_r <= res_vec;
    end
    if (ctl.out_from_skid) begin
      out_r <= skid_r;
    end else if (ctl.out_from_pipe) begin
      out_r <= res_vec;
    end
  end

  assign out_data = out_r;

endmodule

`default_nettype wire

[rtl/core/vector_normalize_3d.sv]
// Top level of the 3D vector normalizer: three component lanes and a merge stage.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------
//  in      | input     | in_valid / in_ready   | vec_in_t  (x_in, y_in, z_in)
//  out     | output    | out_valid / out_ready | vec_out_t (x/y/z_out, ok)
//
//  One item per cycle sustained while out_ready is high. Stages: one square
//  stage, one sum stage, one search stage per result bit, and the output
//  register.
//  Reset (rst_n low, synchronous) clears only valid state; data regs are free.
//  The pipeline stalls as a whole only when both the output register and its
//  skid entry hold results; in_ready is then low until the output drains.
`default_nettype none

module vector_normalize_3d (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  vn3_pkg::vec_in_t    in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output vn3_pkg::vec_out_t   out_data
);
  import vn3_pkg::*;

  ctl_t                           ctl;
  comp_t [NLANES-1:0]             comps;
  logic [NLANES-1:0][QW-1:0]      sq;
  lane_res_t [NLANES-1:0]         lane_res;
  logic [NSRCH-1:0][SW-1:0]       s_stage;

  assign comps[0] = in_data.x_in;
  assign comps[1] = in_data.y_in;
  assign comps[2] = in_data.z_in;

  // handshake, valid pipeline and output skid
  vn3_ctl u_ctl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .ctl       (ctl)
  );

  // one lane per component; all advance on the same enable
  for (genvar i = 0; i < NLANES; i++) begin : g_lane
    vn3_lane u_lane (
      .clk     (clk),
      .en      (ctl.en),
      .comp_in (comps[i]),
      .s_stage (s_stage),
      .sq_out  (sq[i]),
      .res     (lane_res[i])
    );
  end

  // squared length shared by the lanes, special cases, output register
  vn3_merge u_merge (
    .clk      (clk),
    .ctl      (ctl),
    .sq_in    (sq),
    .res_in   (lane_res),
    .s_stage  (s_stage),
    .out_data (out_data)
  );

`ifndef NO_ASSERTIONS
  // back-pressure only when the output side is full
  a_stall_needs_output: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with empty output register");

  // skid drains in the cycle after the output is taken
  a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (!in_ready && out_valid && out_ready) |=> in_ready)
    else $error("skid entry not drained");

  // zero-length vectors give zero components
  a_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.ok) |->
      (out_data.x_out == '0 && out_data.y_out == '0 && out_data.z_out == '0))
    else $error("zero vector with nonzero components");

  // normalized components stay within [-1.0, 1.0]
  a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.ok) |->
      (out_data.x_out <= Q_ONE && out_data.x_out >= -Q_ONE &&
       out_data.y_out <= Q_ONE && out_data.y_out >= -Q_ONE &&
       out_data.z_out <= Q_ONE && out_data.z_out >= -Q_ONE))
    else $error("normalized component out of range");
`endif

endmodule

`default_nettype wire

[test/testbench.sv]
// Self-checking testbench for vector_normalize_3d: directed and random vectors, scored in order.
`timescale 1ns / 1ps

module testbench;
  import vn3_pkg::*;

  localparam int N_RANDOM   = 900;
  localparam int N_CALM     = 120;       // tail of the random part with no idling
  localparam int DRAIN_WAIT = FRAC + 24; // longer than the pipeline latency
  localparam int CYCLE_CAP  = 200000;

  // Tracks the normalized vectors still owed by the block, oldest first.
  class norm_scoreboard;
    vec_out_t expected_norms[$];
    int       error_count = 0;

    // round(mag * 2^FRAC / sqrt(s)), ties away from zero, by bitwise search
    function automatic logic [127:0] unit_scale(logic [127:0] mag, logic [127:0] s);
      logic [127:0] rhs;
      logic [127:0] r;
      logic [127:0] t;
      logic [127:0] d;
      rhs = (mag * mag) << (2 * FRAC + 2);
      r = '0;
      for (int b = FRAC; b >= 0; b--) begin
        t = r | (128'd1 << b);
        if (t <= (128'd1 << FRAC)) begin
          d = 2 * t - 1;
          if (d * d * s <= rhs) r = t;
        end
      end
      return r;
    endfunction

    function automatic comp_t encode_comp(logic [127:0] r, logic neg);
      logic [127:0] half;
      half = 128'd1 << (COMPONENT_BITS - 1);
      if (neg) begin
        if (r > half) r = half;
        return comp_t'(-r);
      end
      if (r > half - 1) r = half - 1;
      return comp_t'(r);
    endfunction

    function automatic vec_out_t predict_norm(vec_in_t v);
      vec_out_t     res;
      comp_t        c [3];
      longint       val;
      logic [127:0] mag [3];
      logic         neg [3];
      logic [127:0] s;
      comp_t        q [3];
      c[0] = v.x_in;
      c[1] = v.y_in;
      c[2] = v.z_in;
      s = '0;
      for (int i = 0; i < 3; i++) begin
        val = c[i];
        neg[i] = val < 0;
        mag[i] = neg[i] ? 128'(-val) : 128'(val);
        s = s + mag[i] * mag[i];
      end
      if (s == 0) begin
        res = '0;
      end else if (s == 128'(S_UNIT)) begin
        // exact unit length passes through untouched
        res.x_out = v.x_in;
        res.y_out = v.y_in;
        res.z_out = v.z_in;
        res.ok    = 1'b1;
      end else begin
        for (int i = 0; i < 3; i++) q[i] = encode_comp(unit_scale(mag[i], s), neg[i]);
        res.x_out = q[0];
        res.y_out = q[1];
        res.z_out = q[2];
        res.ok    = 1'b1;
      end
      return res;
    endfunction

    function void note_vector(vec_in_t v);
      expected_norms.push_back(predict_norm(v));
    endfunction

    function void check_result(vec_out_t got);
      vec_out_t want;
      if (expected_norms.size() == 0) begin
        $display("%0t: unexpected result x=%0d y=%0d z=%0d ok=%0b", $time,
                 got.x_out, got.y_out, got.z_out, got.ok);
        error_count++;
        return;
      end
      want = expected_norms.pop_front();
      if (got.x_out !== want.x_out) begin
        $display("%0t: x_out expected %0d actual %0d", $time, want.x_out, got.x_out);
        error_count++;
      end
      if (got.y_out !== want.y_out) begin
        $display("%0t: y_out expected %0d actual %0d", $time, want.y_out, got.y_out);
        error_count++;
      end
      if (got.z_out !== want.z_out) begin
        $display("%0t: z_out expected %0d actual %0d", $time, want.z_out, got.z_out);
        error_count++;
      end
      if (got.ok !== want.ok) begin
        $display("%0t: ok expected %0b actual %0b", $time, want.ok, got.ok);
        error_count++;
      end
    endfunction

    function int pending();
      return expected_norms.size();
    endfunction
  endclass

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_ready;
  vec_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  vec_out_t out_data;

  bit       calm      = 1'b0;  // set for the tail of the run: no idling anywhere
  int       cycle_cnt = 0;

  norm_scoreboard sb = new();

  vector_normalize_3d DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #6 clk = ~clk;

  // Hard stop in case the block hangs or loses results.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_CAP) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Every accepted result goes straight to the scoreboard.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
  end

  // Result side: ready with random stall bursts, steady once calm is set.
  initial begin
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!calm && $urandom_range(0, 2) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  function automatic vec_in_t make_vec(int x, int y, int z);
    vec_in_t v;
    v.x_in = comp_t'(x);
    v.y_in = comp_t'(y);
    v.z_in = comp_t'(z);
    return v;
  endfunction

  function automatic comp_t rand_comp(int mode);
    case (mode)
      0:       return comp_t'($urandom());
      1:       return comp_t'($signed($urandom_range(0, 16)) - 8);
      2:       return comp_t'($signed($urandom_range(0, 512)) - 256);
      default: return '0;
    endcase
  endfunction

  // Mix of full-range vectors, tiny ones, near-axis ones and exact extremes.
  function automatic vec_in_t rand_vec();
    vec_in_t v;
    int      sel;
    int      axis;
    comp_t   big;
    sel = $urandom_range(0, 9);
    case (sel)
      0, 1, 2, 3: begin
        v = vec_in_t'({$urandom(), $urandom()});
      end
      4: begin
        v.x_in = rand_comp(1);
        v.y_in = rand_comp(1);
        v.z_in = rand_comp(1);
      end
      5, 6: begin
        // one dominant axis, the others small
        axis = $urandom_range(0, 2);
        big  = comp_t'($urandom());
        v.x_in = (axis == 0) ? big : rand_comp(2);
        v.y_in = (axis == 1) ? big : rand_comp(2);
        v.z_in = (axis == 2) ? big : rand_comp(2);
      end
      7: begin
        // unit axis vector, zero vector, or most negative code
        axis = $urandom_range(0, 2);
        case ($urandom_range(0, 3))
          0:       big = Q_ONE;
          1:       big = -Q_ONE;
          2:       big = comp_t'(NEG_MAG);
          default: big = '0;
        endcase
        v = '0;
        if (axis == 0) v.x_in = big;
        if (axis == 1) v.y_in = big;
        if (axis == 2) v.z_in = big;
      end
      default: begin
        // some components zero, the rest full range
        v.x_in = $urandom_range(0, 1) ? rand_comp(0) : '0;
        v.y_in = $urandom_range(0, 1) ? rand_comp(0) : '0;
        v.z_in = $urandom_range(0, 1) ? rand_comp(0) : '0;
      end
    endcase
    return v;
  endfunction

  // Present one vector, optionally after an idle burst, and hold it until taken.
  task automatic send_vec(vec_in_t v);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= v;
    do @(posedge clk); while (!in_ready);
    sb.note_vector(v);
  endtask

  initial begin
    vec_in_t directed[$];

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero vector, exact unit length on each axis and with both signs, extremes,
    // the most negative code, the largest positive code, tiny vectors
    directed.push_back(make_vec(0, 0, 0));
    directed.push_back(make_vec(16384, 0, 0));
    directed.push_back(make_vec(0, -16384, 0));
    directed.push_back(make_vec(0, 0, 16384));
    directed.push_back(make_vec(-16384, 0, 0));
    directed.push_back(make_vec(-32768, 0, 0));
    directed.push_back(make_vec(0, 0, -32768));
    directed.push_back(make_vec(-32768, -32768, -32768));
    directed.push_back(make_vec(32767, 32767, 32767));
    directed.push_back(make_vec(32767, -32768, 32767));
    directed.push_back(make_vec(1, 0, 0));
    directed.push_back(make_vec(0, 0, -1));
    directed.push_back(make_vec(1, 1, 1));
    directed.push_back(make_vec(-1, 1, -1));
    directed.push_back(make_vec(3, 4, 0));
    directed.push_back(make_vec(16383, 0, 0));
    directed.push_back(make_vec(16385, 0, 0));
    directed.push_back(make_vec(8192, 8192, 8192));
    directed.push_back(make_vec(32767, 1, -1));
    directed.push_back(make_vec(-21846, 21845, 0));

    foreach (directed[i]) send_vec(directed[i]);

    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == N_RANDOM - N_CALM) calm = 1'b1;
      send_vec(rand_vec());
    end
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (sb.error_count == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/core/vn3_pkg.sv
rtl/core/vn3_ctl.sv
rtl/core/vn3_lane.sv
rtl/core/vn3_merge.sv
rtl/core/vector_normalize_3d.sv
test/testbench.sv
